[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PPPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ppps assertion failed");

// Next-cycle implication, disabled while reset is low
`define PPPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ppps assertion failed");

`endif

[hw/rtl/ppps_pkg.sv]
// Package for the plane/sphere projection core: widths, codes, payload types
// and the rounding and saturation helpers. No dependencies.
package ppps_pkg;

  // Field widths
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MIN_LENGTH = 1;
  localparam int KIND_W     = 2;
  localparam int NORM_W     = 18;
  localparam int RAD_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  // Datapath widths
  localparam int DIFF_W = COORD_W + 1;           // vertex - anchor
  localparam int SQ_W   = 2 * DIFF_W;            // one squared component
  localparam int SUM_W  = 2 * DIFF_W + 2;        // sum of squares, even
  localparam int LEN_W  = SUM_W / 2;             // square root
  localparam int REM_W  = LEN_W + 4;             // root remainder
  localparam int PROD_W = DIFF_W + NORM_W;       // d * n
  localparam int DOT_W  = PROD_W + 2;            // d . n
  localparam int T_W    = DOT_W - FRAC_BITS + 1; // plane distance t
  localparam int TN_W   = T_W + NORM_W;          // t * n
  localparam int RND_W  = DOT_W + NORM_W;        // rounding helper width
  localparam int WIDE_W = RND_W + 1;             // pre-saturation width
  localparam int NUM_W  = DIFF_W + RAD_W + 1;    // divider numerator
  localparam int Q_W    = RAD_W + 1;             // divider quotient
  localparam int CMP_W  = LEN_W + Q_W;           // divider compare width

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 2'd0,
    KIND_PLANE  = 2'd1,
    KIND_SPHERE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_GEOM   = 2'd1,
    ST_AT_CENTRE = 2'd2,
    ST_RAD_SMALL = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KIND   = 3'd0,
    CFG_ANC_X  = 3'd1,
    CFG_ANC_Y  = 3'd2,
    CFG_ANC_Z  = 3'd3,
    CFG_NRM_X  = 3'd4,
    CFG_NRM_Y  = 3'd5,
    CFG_NRM_Z  = 3'd6,
    CFG_RADIUS = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
    logic signed [COORD_W-1:0] result_z;
    logic [1:0]                status;
  } out_rsp_t;

  // Per-item data carried alongside the sqrt and divide pipelines
  typedef struct packed {
    logic                    func;
    logic [2:0][COORD_W-1:0] v;
    logic [2:0][DIFF_W-1:0]  d;
    logic [2:0][COORD_W-1:0] pres;  // plane snap result
    logic [LEN_W-1:0]        len;
  } side_t;

  // Divide by 2^FRAC_BITS, round to nearest, ties away from zero
  function automatic logic signed [RND_W-1:0] rdiv_one(logic signed [RND_W-1:0] x);
    logic [RND_W-1:0] mag;
    logic [RND_W-1:0] qm;
    mag = x[RND_W-1] ? RND_W'(-x) : RND_W'(x);
    qm  = (mag + (RND_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[RND_W-1] ? -$signed(qm) : $signed(qm);
  endfunction

  // Clamp to the signed coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return hi[COORD_W-1:0];
    end else if (x < lo) begin
      return lo[COORD_W-1:0];
    end
    return x[COORD_W-1:0];
  endfunction

endpackage

[hw/rtl/project_point_to_plane_or_sphere_core.sv]
// Projects vertices onto a configured plane or sphere, or returns the surface
// normal there, in signed Q16.16. One request is taken per clock unless stalled.
// Stages: 5 front stages (difference, products, sums, plane distance,
// plane offset), a 34-stage square root (one root bit per stage), 2 numerator
// stages, a 32-stage divider (one quotient bit per stage, three lanes) and the
// output register. The whole pipeline holds while a result waits at the
// output, so in_ready_o is low exactly then. Write configuration only while
// no request is in flight. Depends on ppps_pkg, ppps_sqrt and ppps_div.
module project_point_to_plane_or_sphere_core import ppps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_rsp_t              out_rsp_o
);

  // Configuration registers
  logic [KIND_W-1:0]       kind_q;
  logic [2:0][COORD_W-1:0] anc_q;
  logic [2:0][NORM_W-1:0]  nrm_q;
  logic [RAD_W-1:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_NONE;
      anc_q  <= '0;
      nrm_q  <= {NORM_W'(1) << FRAC_BITS, NORM_W'(0), NORM_W'(0)};
      rad_q  <= RAD_W'(1) << FRAC_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KIND:   kind_q   <= cfg_wdata_i[KIND_W-1:0];
        CFG_ANC_X:  anc_q[0] <= cfg_wdata_i[COORD_W-1:0];
        CFG_ANC_Y:  anc_q[1] <= cfg_wdata_i[COORD_W-1:0];
        CFG_ANC_Z:  anc_q[2] <= cfg_wdata_i[COORD_W-1:0];
        CFG_NRM_X:  nrm_q[0] <= cfg_wdata_i[NORM_W-1:0];
        CFG_NRM_Y:  nrm_q[1] <= cfg_wdata_i[NORM_W-1:0];
        CFG_NRM_Z:  nrm_q[2] <= cfg_wdata_i[NORM_W-1:0];
        CFG_RADIUS: rad_q    <= cfg_wdata_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: everything moves unless the output is stalled
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Front stages
  side_t                     s1_d, s1_q, s2_q, s3_q, s4_q, s5_q, s5_x;
  logic [DIFF_W-1:0]         mag1 [3];
  logic signed [PROD_W-1:0]  prod_q [3];
  logic [SQ_W-1:0]           sq_q [3];
  logic [SUM_W-1:0]          sum3_q, sum4_q, sum5_q;
  logic signed [DOT_W-1:0]   dot_q;
  logic signed [T_W-1:0]     t_d, t_q;
  logic signed [TN_W-1:0]    tn_q [3];
  logic [4:0]                fv_q;

  // difference to the anchor
  always_comb begin
    s1_d      = '0;
    s1_d.func = in_req_i.func;
    s1_d.v[0] = in_req_i.vertex_x;
    s1_d.v[1] = in_req_i.vertex_y;
    s1_d.v[2] = in_req_i.vertex_z;
    for (int i = 0; i < 3; i++) begin
      s1_d.d[i] = {s1_d.v[i][COORD_W-1], s1_d.v[i]} - {anc_q[i][COORD_W-1], anc_q[i]};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] = s1_q.d[i][DIFF_W-1] ? DIFF_W'(-s1_q.d[i]) : s1_q.d[i];
    end
  end

  assign t_d = T_W'(rdiv_one(RND_W'(dot_q)));

  // plane snap: v - round(t * n)
  always_comb begin
    s5_x = s5_q;
    for (int i = 0; i < 3; i++) begin
      s5_x.pres[i] = sat_coord(WIDE_W'($signed(s5_q.v[i]))
                               - WIDE_W'(rdiv_one(RND_W'(tn_q[i]))));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= $signed(s1_q.d[i]) * $signed(nrm_q[i]);
        sq_q[i]   <= mag1[i] * mag1[i];
      end
      s3_q   <= s2_q;
      sum3_q <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      dot_q  <= DOT_W'(prod_q[0]) + DOT_W'(prod_q[1]) + DOT_W'(prod_q[2]);
      s4_q   <= s3_q;
      sum4_q <= sum3_q;
      t_q    <= t_d;
      s5_q   <= s4_q;
      sum5_q <= sum4_q;
      for (int i = 0; i < 3; i++) begin
        tn_q[i] <= t_q * $signed(nrm_q[i]);
      end
    end
  end

  // Square root of the squared distance
  logic             sq_vld;
  logic [LEN_W-1:0] sq_root;
  side_t            sq_side;

  ppps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv_q[4]),
    .rad_i   (sum5_q),
    .side_i  (s5_x),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Numerators: |d| * radius for a snap, |d| << FRAC_BITS for a normal
  side_t                 p1_d, p1_q, p2_q;
  logic [DIFF_W-1:0]     magp [3];
  logic [2:0][NUM_W-1:0] num1_d, num1_q, num2_q;
  logic [1:0]            pv_q;

  always_comb begin
    p1_d     = sq_side;
    p1_d.len = sq_root;
    for (int i = 0; i < 3; i++) begin
      magp[i]   = sq_side.d[i][DIFF_W-1] ? DIFF_W'(-sq_side.d[i]) : sq_side.d[i];
      num1_d[i] = sq_side.func ? NUM_W'(magp[i] * rad_q)
                               : (NUM_W'(magp[i]) << FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= p1_d;
      num1_q <= num1_d;
      p2_q   <= p1_q;
      for (int i = 0; i < 3; i++) begin
        num2_q[i] <= num1_q[i] + NUM_W'(p1_q.len >> 1);
      end
    end
  end

  // Divide by the length
  logic                dv_vld;
  logic [2:0][Q_W-1:0] dv_q;
  side_t               dv_side;

  ppps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pv_q[1]),
    .num_i   (num2_q),
    .side_i  (p2_q),
    .valid_o (dv_vld),
    .q_o     (dv_q),
    .side_o  (dv_side)
  );

  // Result selection and status
  logic [COORD_W-1:0]      res [3];
  logic [1:0]              st;
  logic                    len_small;
  logic                    rad_small;
  logic signed [WIDE_W-1:0] qs;
  out_rsp_t                out_d, out_q;
  logic                    out_valid_q;

  assign len_small = (dv_side.len < LEN_W'(MIN_LENGTH));
  assign rad_small = (rad_q < RAD_W'(MIN_LENGTH));

  always_comb begin
    st = ST_NO_GEOM;
    qs = '0;
    for (int i = 0; i < 3; i++) begin
      res[i] = dv_side.func ? dv_side.v[i] : '0;
      qs = dv_side.d[i][DIFF_W-1] ? -WIDE_W'(dv_q[i]) : WIDE_W'(dv_q[i]);
      case (kind_e'(kind_q))
        KIND_PLANE: begin
          st     = ST_OK;
          res[i] = dv_side.func ? dv_side.pres[i] : sat_coord(WIDE_W'($signed(nrm_q[i])));
        end
        KIND_SPHERE: begin
          if (len_small) begin
            st = ST_AT_CENTRE;
          end else begin
            st     = rad_small ? ST_RAD_SMALL : ST_OK;
            res[i] = dv_side.func ? sat_coord(WIDE_W'($signed(anc_q[i])) + qs)
                                  : sat_coord(qs);
          end
        end
        default: st = ST_NO_GEOM;
      endcase
    end
    out_d.result_x = res[0];
    out_d.result_y = res[1];
    out_d.result_z = res[2];
    out_d.status   = st;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // Valid bits of the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q        <= '0;
      pv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      fv_q        <= {fv_q[3:0], in_valid_i};
      pv_q        <= {pv_q[0], sq_vld};
      out_valid_q <= dv_vld;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

[hw/rtl/ppps_sqrt.sv]
// Pipelined integer square root, one result bit per stage, carrying the
// item's side data. Depends on ppps_pkg.
module ppps_sqrt import ppps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SUM_W-1:0] rad_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [LEN_W-1:0] root_o,
  output side_t            side_o
);

  logic [SUM_W-1:0] rad_q  [LEN_W];
  logic [REM_W-1:0] rem_q  [LEN_W];
  logic [LEN_W-1:0] root_q [LEN_W];
  side_t            side_q [LEN_W];
  logic             vld_q  [LEN_W];

  for (genvar k = 0; k < LEN_W; k++) begin : g_st
    logic [SUM_W-1:0] rin;
    logic [REM_W-1:0] remin;
    logic [REM_W-1:0] remx;
    logic [REM_W-1:0] trial;
    logic [LEN_W-1:0] rootin;
    side_t            sin;
    logic             vin;
    logic             ge;

    if (k == 0) begin : g_first
      assign rin    = rad_i;
      assign remin  = '0;
      assign rootin = '0;
      assign sin    = side_i;
      assign vin    = valid_i;
    end else begin : g_next
      assign rin    = rad_q[k-1];
      assign remin  = rem_q[k-1];
      assign rootin = root_q[k-1];
      assign sin    = side_q[k-1];
      assign vin    = vld_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign remx  = {remin[REM_W-3:0], rin[SUM_W-1 -: 2]};
    assign trial = REM_W'({rootin, 2'b01});
    assign ge    = (remx >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rin << 2;
        rem_q[k]  <= ge ? (remx - trial) : remx;
        root_q[k] <= {rootin[LEN_W-2:0], ge};
        side_q[k] <= sin;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end
  end

  assign valid_o = vld_q[LEN_W-1];
  assign root_o  = root_q[LEN_W-1];
  assign side_o  = side_q[LEN_W-1];

endmodule

[hw/rtl/ppps_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor (side.len),
// one quotient bit per stage. Depends on ppps_pkg.
module ppps_div import ppps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2:0][NUM_W-1:0] num_i,
  input  side_t                 side_i,
  output logic                  valid_o,
  output logic [2:0][Q_W-1:0]   q_o,
  output side_t                 side_o
);

  logic [2:0][NUM_W-1:0] rem_q  [Q_W];
  logic [2:0][Q_W-1:0]   quo_q  [Q_W];
  side_t                 side_q [Q_W];
  logic                  vld_q  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    localparam int SH = Q_W - 1 - k;
    logic [2:0][NUM_W-1:0] remin;
    logic [2:0][NUM_W-1:0] remn;
    logic [2:0][Q_W-1:0]   qin;
    logic [2:0][Q_W-1:0]   qn;
    logic [CMP_W-1:0]      cmp;
    side_t                 sin;
    logic                  vin;

    if (k == 0) begin : g_first
      assign remin = num_i;
      assign qin   = '0;
      assign sin   = side_i;
      assign vin   = valid_i;
    end else begin : g_next
      assign remin = rem_q[k-1];
      assign qin   = quo_q[k-1];
      assign sin   = side_q[k-1];
      assign vin   = vld_q[k-1];
    end

    // divisor aligned to this quotient bit
    assign cmp = CMP_W'(sin.len) << SH;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (CMP_W'(remin[l]) >= cmp) begin
          remn[l] = remin[l] - cmp[NUM_W-1:0];
          qn[l]   = {qin[l][Q_W-2:0], 1'b1};
        end else begin
          remn[l] = remin[l];
          qn[l]   = {qin[l][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= remn;
        quo_q[k]  <= qn;
        side_q[k] <= sin;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign q_o     = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

[hw/rtl/ppps_checker.sv]
// Port-level checker for the projection core, bound to the top level.
// Depends on ppps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppps_checker import ppps_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input in_req_t               in_req_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input out_rsp_t              out_rsp_o
);

  // Shadow of the geometry kind as seen on the config port
  logic [KIND_W-1:0] kind_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_sh_q <= KIND_NONE;
    end else if (cfg_we_i && (cfg_idx_i == CFG_KIND)) begin
      kind_sh_q <= cfg_wdata_i[KIND_W-1:0];
    end
  end

  // a waiting request holds
  `PPPS_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_req_i))

  // a stalled result holds
  `PPPS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

  // status follows the configured geometry
  `PPPS_ASSERT_IMP(a_none_status, clk_i, rst_ni, out_valid_o && (kind_sh_q != KIND_PLANE) && (kind_sh_q != KIND_SPHERE), out_rsp_o.status == ST_NO_GEOM)
  `PPPS_ASSERT_IMP(a_plane_status, clk_i, rst_ni, out_valid_o && (kind_sh_q == KIND_PLANE), out_rsp_o.status == ST_OK)
  `PPPS_ASSERT_IMP(a_sphere_status, clk_i, rst_ni, out_valid_o && (kind_sh_q == KIND_SPHERE), out_rsp_o.status != ST_NO_GEOM)

endmodule

bind project_point_to_plane_or_sphere_core ppps_checker u_ppps_checker (.*);
